FILE: hdl/cleb_pkg.sv
package cleb_pkg;

  // Number of characters the line can hold.
  localparam int CAPACITY = 64;
  // Width of a count that runs from zero up to CAPACITY.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Width of a cell index.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [7:0] KEY_LEFT  = 8'h3C;
  localparam logic [7:0] KEY_RIGHT = 8'h3E;
  localparam logic [7:0] KEY_BACK  = 8'h2D;

  // What the row of cells does in the current cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [IDX_W-1:0]   pos;
  } cell_ctrl_t;

endpackage

FILE: hdl/cleb_cell.sv
module cleb_cell
  import cleb_pkg::*;
(
  input  logic             clk_i,
  input  logic [IDX_W-1:0] index_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [7:0]       key_i,
  input  logic [7:0]       left_i,
  input  logic [7:0]       right_i,
  output logic [7:0]       data_o
);

  logic [7:0] data_q;
  logic [7:0] data_d;

  // An insert opens a slot at the position and pushes the cells above it up.
  // A delete closes the slot at the position by pulling the cells above down.
  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_INS: begin
        if (index_i == ctrl_i.pos) begin
          data_d = key_i;
        end else if (index_i > ctrl_i.pos) begin
          data_d = left_i;
        end
      end
      CELL_DEL: begin
        if (index_i >= ctrl_i.pos) begin
          data_d = right_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: hdl/cursor_line_edit_buffer_core.sv
// Line editor with a cursor. The line is held in order in a row of CAPACITY
// character cells; the cursor is a count of the characters to its left.
// Keystroke requests are accepted back to back while editing: '<' and
// '>' move the cursor, '-' deletes the character before it, and any other
// byte is inserted at the cursor, the cells above shifting up by one. An
// insert into a full line is dropped and sets a sticky overflow flag. An
// end-of-line request empties the line: the row shifts down one cell per
// cycle while the output is not stalled and cell 0 goes out as one result;
// an empty line gives one result marked empty. Input is stalled while the
// line is emitted; the line is then cleared and the flag reset. A result
// register sits at the output, so the next keystroke is taken while the
// last result of a line still waits to be taken.
module cursor_line_edit_buffer_core
  import cleb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] key_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       last_o,
  output logic       empty_line_o,
  output logic       overflowed_o
);

  typedef enum logic {
    ST_EDIT,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] len_q;
  logic [CNT_W-1:0] cur_q;
  logic             ovf_q;
  logic             out_valid_q;
  logic [7:0]       out_char_q;
  logic             last_q;
  logic             empty_q;
  logic             ovf_out_q;

  logic             in_take;
  logic             out_free;
  logic [CNT_W-1:0] cur_m1;
  logic             is_full;
  cell_ctrl_t       ctrl;
  logic [7:0]       cell_data [CAPACITY];

  assign in_stall_o = (state_q != ST_EDIT);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cur_m1     = cur_q - CNT_W'(1);
  assign is_full    = (len_q == CNT_W'(CAPACITY));

  // Command to the row of cells for this cycle.
  always_comb begin
    ctrl.op  = CELL_HOLD;
    ctrl.pos = '0;
    if (in_take && !command_i) begin
      if (key_byte_i == KEY_BACK) begin
        if (cur_q != '0) begin
          ctrl.op  = CELL_DEL;
          ctrl.pos = cur_m1[IDX_W-1:0];
        end
      end else if (key_byte_i != KEY_LEFT && key_byte_i != KEY_RIGHT) begin
        if (!is_full) begin
          ctrl.op  = CELL_INS;
          ctrl.pos = cur_q[IDX_W-1:0];
        end
      end
    end else if (state_q == ST_EMIT && out_free && len_q != '0) begin
      // Shift the whole line down by one; cell 0 is going out.
      ctrl.op  = CELL_DEL;
      ctrl.pos = '0;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [7:0] left_data;
    logic [7:0] right_data;

    if (g == 0) begin : g_first
      assign left_data = 8'h00;
    end else begin : g_inner_l
      assign left_data = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_final
      assign right_data = 8'h00;
    end else begin : g_inner_r
      assign right_data = cell_data[g+1];
    end

    cleb_cell u_cell (
      .clk_i   (clk_i),
      .index_i (IDX_W'(g)),
      .ctrl_i  (ctrl),
      .key_i   (key_byte_i),
      .left_i  (left_data),
      .right_i (right_data),
      .data_o  (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_EDIT;
      len_q       <= '0;
      cur_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_char_q  <= 8'h00;
      last_q      <= 1'b0;
      empty_q     <= 1'b0;
      ovf_out_q   <= 1'b0;
    end else begin
      // While emitting, a free output register is always refilled below.
      if (out_valid_q && !out_stall_i && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_EDIT: begin
          if (in_take) begin
            if (command_i) begin
              state_q <= ST_EMIT;
            end else if (key_byte_i == KEY_LEFT) begin
              if (cur_q != '0) begin
                cur_q <= cur_m1;
              end
            end else if (key_byte_i == KEY_RIGHT) begin
              if (cur_q != len_q) begin
                cur_q <= cur_q + CNT_W'(1);
              end
            end else if (key_byte_i == KEY_BACK) begin
              if (cur_q != '0) begin
                cur_q <= cur_m1;
                len_q <= len_q - CNT_W'(1);
              end
            end else if (is_full) begin
              ovf_q <= 1'b1;
            end else begin
              cur_q <= cur_q + CNT_W'(1);
              len_q <= len_q + CNT_W'(1);
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            ovf_out_q   <= ovf_q;
            if (len_q == '0) begin
              // Empty line: a single marked result.
              out_char_q <= 8'h00;
              last_q     <= 1'b1;
              empty_q    <= 1'b1;
              state_q    <= ST_EDIT;
              cur_q      <= '0;
              ovf_q      <= 1'b0;
            end else begin
              out_char_q <= cell_data[0];
              last_q     <= (len_q == CNT_W'(1));
              empty_q    <= 1'b0;
              len_q      <= len_q - CNT_W'(1);
              if (len_q == CNT_W'(1)) begin
                state_q <= ST_EDIT;
                cur_q   <= '0;
                ovf_q   <= 1'b0;
              end
            end
          end
        end
        default: begin
          state_q <= ST_EDIT;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign last_o       = last_q;
  assign empty_line_o = empty_q;
  assign overflowed_o = ovf_out_q;

endmodule
